// File: rtl/psc_pkg.sv
// Package for the pressure sensor compensation block: constants, register codes,
// pipeline stage positions. No dependencies.
`default_nettype none
package psc_pkg;

    localparam int RAW_W      = 20;
    localparam int TEMP_W     = 32;
    localparam int OUT_W      = 32;
    localparam int COEF_W     = 16;
    localparam int DW         = 64;
    localparam int DIV_W      = 64;
    localparam int ADDR_W     = 5;
    localparam int APB_W      = 32;

    localparam logic [DW-1:0] TEMP_OFFSET = 64'd128000;
    localparam logic [DW-1:0] PRESS_FULL  = 64'd1048576;
    localparam logic [DW-1:0] NUM_SCALE   = 64'd3125;
    localparam logic [DW-1:0] DIV_BIAS    = 64'h0000_8000_0000_0000;

    // stage positions along the item pipeline
    localparam int S_DEN      = 8;
    localparam int S_DIV_IN   = 11;
    localparam int S_DIV_OUT  = S_DIV_IN + DIV_W;
    localparam int PIPE_LAT   = S_DIV_OUT + 8;

    typedef enum logic [2:0] {
        REG_P1    = 3'd0,
        REG_P2    = 3'd1,
        REG_P3    = 3'd2,
        REG_P4    = 3'd3,
        REG_P5    = 3'd4,
        REG_P6    = 3'd5,
        REG_P7    = 3'd6,
        REG_P8_P9 = 3'd7
    } t_reg_idx;

endpackage
`default_nettype wire

// File: rtl/psc_if.sv
// Stream interfaces for samples in and compensated results out.
// Depends on psc_pkg for field widths.
`default_nettype none
interface psc_sample_if;
    logic                           valid;
    logic                           ready;
    logic [psc_pkg::RAW_W-1:0]      raw_pressure;
    logic signed [psc_pkg::TEMP_W-1:0] fine_temperature;

    modport source (output valid, output raw_pressure, output fine_temperature, input ready);
    modport sink   (input valid, input raw_pressure, input fine_temperature, output ready);
endinterface

interface psc_result_if;
    logic                          valid;
    logic                          ready;
    logic [psc_pkg::OUT_W-1:0]     pressure_q24_8;
    logic                          divisor_fault;

    modport source (output valid, output pressure_q24_8, output divisor_fault, input ready);
    modport sink   (input valid, input pressure_q24_8, input divisor_fault, output ready);
endinterface
`default_nettype wire

// File: rtl/psc_mul.sv
// Two-stage 64x64 multiplier, product modulo 2^64, built from 32x32 partial products.
// Depends on psc_pkg.
`default_nettype none
module psc_mul (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [psc_pkg::DW-1:0]    i_a,
    input  wire logic [psc_pkg::DW-1:0]    i_b,
    output logic      [psc_pkg::DW-1:0]    o_p
);
    localparam int HW = psc_pkg::DW / 2;

    logic [psc_pkg::DW-1:0] r_lo;
    logic [HW-1:0]          r_x1;
    logic [HW-1:0]          r_x2;
    logic [psc_pkg::DW-1:0] n_lo;
    logic [HW-1:0]          n_x1;
    logic [HW-1:0]          n_x2;
    logic [HW-1:0]          w_cross;

    assign n_lo    = psc_pkg::DW'(i_a[HW-1:0]) * psc_pkg::DW'(i_b[HW-1:0]);
    assign n_x1    = i_a[HW-1:0] * i_b[psc_pkg::DW-1:HW];
    assign n_x2    = i_a[psc_pkg::DW-1:HW] * i_b[HW-1:0];
    assign w_cross = r_x1 + r_x2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo <= n_lo;
            r_x1 <= n_x1;
            r_x2 <= n_x2;
            o_p  <= r_lo + {w_cross, {HW{1'b0}}};
        end
    end
endmodule
`default_nettype wire

// File: rtl/psc_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on psc_pkg.
`default_nettype none
module psc_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [psc_pkg::DW-1:0]    i_num,
    input  wire logic [psc_pkg::DW-1:0]    i_den,
    output logic      [psc_pkg::DW-1:0]    o_quo
);
    localparam int W = psc_pkg::DW;
    localparam int N = psc_pkg::DIV_W;

    logic [W-1:0] r_rem [0:N-1];
    logic [W-1:0] r_num [0:N-1];
    logic [W-1:0] r_den [0:N-1];
    logic [W-1:0] r_quo [0:N-1];

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_stage
            logic [W-1:0] w_rem;
            logic [W-1:0] w_num;
            logic [W-1:0] w_den;
            logic [W-1:0] w_quo;
            logic [W:0]   w_sh;
            logic [W:0]   w_diff;
            if (g == 0) begin : g_first
                assign w_rem = '0;
                assign w_num = i_num;
                assign w_den = i_den;
                assign w_quo = '0;
            end else begin : g_next
                assign w_rem = r_rem[g-1];
                assign w_num = r_num[g-1];
                assign w_den = r_den[g-1];
                assign w_quo = r_quo[g-1];
            end
            assign w_sh   = {w_rem, w_num[W-1]};
            assign w_diff = w_sh - {1'b0, w_den};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= w_diff[W] ? w_sh[W-1:0] : w_diff[W-1:0];
                    r_num[g] <= {w_num[W-2:0], 1'b0};
                    r_den[g] <= w_den;
                    r_quo[g] <= {w_quo[W-2:0], ~w_diff[W]};
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[N-1] ^ (r_rem[N-1] & r_num[N-1] & r_den[N-1] & '0);
endmodule
`default_nettype wire

// File: rtl/pressure_sensor_compensation.sv
// Top level of the pressure compensation block: APB coefficient registers and the
// item pipeline. Depends on psc_pkg, psc_if, psc_mul and psc_div.
//
//   channel    dir  handshake       payload
//   i_sample   in   valid/ready     raw_pressure[19:0], fine_temperature[31:0] signed
//   o_result   out  valid/ready     pressure_q24_8[31:0], divisor_fault
//   apb        in   psel/penable    paddr[4:2] selects coef_p1..coef_p8_p9, pwdata[31:0]
//
// One transfer enters per cycle while the output is not stalled; each result follows its
// sample through the PIPE_LAT register stages: six chained multipliers and a 64-stage
// divider, one quotient bit per stage, set the depth. Valid bits travel with the data.
// Reset clears the valid bits and the coefficients; payload registers keep no reset.
// A stall at the output freezes the whole pipeline in place, so nothing is lost or
// repeated; ready goes low only while the last stage holds an untaken result.
`default_nettype none
module pressure_sensor_compensation (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    psc_sample_if.sink                             i_sample,
    psc_result_if.source                           o_result,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [psc_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [psc_pkg::APB_W-1:0]         pwdata,
    output logic      [psc_pkg::APB_W-1:0]         prdata,
    output logic                                   pready
);
    localparam int DW  = psc_pkg::DW;
    localparam int LAT = psc_pkg::PIPE_LAT;
    localparam int CW  = psc_pkg::COEF_W;

    // ---------------- coefficient registers ----------------
    logic [CW-1:0] r_p1, r_p2, r_p3, r_p4, r_p5, r_p6, r_p7;
    logic [psc_pkg::APB_W-1:0] r_p89;
    psc_pkg::t_reg_idx w_idx;

    assign w_idx  = psc_pkg::t_reg_idx'(paddr[psc_pkg::ADDR_W-1:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1  <= '0;
            r_p2  <= '0;
            r_p3  <= '0;
            r_p4  <= '0;
            r_p5  <= '0;
            r_p6  <= '0;
            r_p7  <= '0;
            r_p89 <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                psc_pkg::REG_P1:    r_p1  <= pwdata[CW-1:0];
                psc_pkg::REG_P2:    r_p2  <= pwdata[CW-1:0];
                psc_pkg::REG_P3:    r_p3  <= pwdata[CW-1:0];
                psc_pkg::REG_P4:    r_p4  <= pwdata[CW-1:0];
                psc_pkg::REG_P5:    r_p5  <= pwdata[CW-1:0];
                psc_pkg::REG_P6:    r_p6  <= pwdata[CW-1:0];
                psc_pkg::REG_P7:    r_p7  <= pwdata[CW-1:0];
                psc_pkg::REG_P8_P9: r_p89 <= pwdata;
                default:            r_p89 <= r_p89;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            psc_pkg::REG_P1:    prdata = {16'b0, r_p1};
            psc_pkg::REG_P2:    prdata = {16'b0, r_p2};
            psc_pkg::REG_P3:    prdata = {16'b0, r_p3};
            psc_pkg::REG_P4:    prdata = {16'b0, r_p4};
            psc_pkg::REG_P5:    prdata = {16'b0, r_p5};
            psc_pkg::REG_P6:    prdata = {16'b0, r_p6};
            psc_pkg::REG_P7:    prdata = {16'b0, r_p7};
            psc_pkg::REG_P8_P9: prdata = r_p89;
            default:            prdata = '0;
        endcase
    end

    // sign-extended coefficients; p1 is unsigned
    logic [DW-1:0] w_p1, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;
    assign w_p1 = {48'b0, r_p1};
    assign w_p2 = {{48{r_p2[CW-1]}}, r_p2};
    assign w_p3 = {{48{r_p3[CW-1]}}, r_p3};
    assign w_p4 = {{48{r_p4[CW-1]}}, r_p4};
    assign w_p5 = {{48{r_p5[CW-1]}}, r_p5};
    assign w_p6 = {{48{r_p6[CW-1]}}, r_p6};
    assign w_p7 = {{48{r_p7[CW-1]}}, r_p7};
    assign w_p8 = {{48{r_p89[CW-1]}}, r_p89[CW-1:0]};
    assign w_p9 = {{48{r_p89[2*CW-1]}}, r_p89[2*CW-1:CW]};

    // ---------------- pipeline control ----------------
    logic [LAT-1:0] r_vld;
    logic           w_en;

    // advance whenever the last stage is empty or being taken
    assign w_en           = !r_vld[LAT-1] || o_result.ready;
    assign i_sample.ready = w_en;
    assign o_result.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_sample.valid};
        end
    end

    // raw reading rides along to the output for the fault pass-through
    logic [psc_pkg::RAW_W-1:0] r_raw [0:LAT-2];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_raw[0] <= i_sample.raw_pressure;
            for (int k = 1; k < LAT - 1; k++) begin
                r_raw[k] <= r_raw[k-1];
            end
        end
    end

    // ---------------- stage 0: offsets ----------------
    logic [DW-1:0] r_a0;
    logic [DW-1:0] r_praw [0:7];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a0     <= {{32{i_sample.fine_temperature[psc_pkg::TEMP_W-1]}},
                         i_sample.fine_temperature} - psc_pkg::TEMP_OFFSET;
            r_praw[0] <= psc_pkg::PRESS_FULL - DW'(i_sample.raw_pressure);
            for (int k = 1; k < 8; k++) begin
                r_praw[k] <= r_praw[k-1];
            end
        end
    end

    // ---------------- stages 1-2: a*a, a*p5, a*p2 ----------------
    logic [DW-1:0] w_aa, w_ap5, w_ap2;
    psc_mul u_mul_aa  (.i_clk, .i_en(w_en), .i_a(r_a0), .i_b(r_a0), .o_p(w_aa));
    psc_mul u_mul_ap5 (.i_clk, .i_en(w_en), .i_a(r_a0), .i_b(w_p5), .o_p(w_ap5));
    psc_mul u_mul_ap2 (.i_clk, .i_en(w_en), .i_a(r_a0), .i_b(w_p2), .o_p(w_ap2));

    // ---------------- stages 3-4: a*a*p6, a*a*p3 ----------------
    logic [DW-1:0] w_b6, w_a3;
    logic [DW-1:0] r_ap5 [0:1];
    logic [DW-1:0] r_ap2 [0:1];
    psc_mul u_mul_b6 (.i_clk, .i_en(w_en), .i_a(w_aa), .i_b(w_p6), .o_p(w_b6));
    psc_mul u_mul_a3 (.i_clk, .i_en(w_en), .i_a(w_aa), .i_b(w_p3), .o_p(w_a3));
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ap5[0] <= w_ap5;
            r_ap5[1] <= r_ap5[0];
            r_ap2[0] <= w_ap2;
            r_ap2[1] <= r_ap2[0];
        end
    end

    // ---------------- stage 5: offset term and divisor base ----------------
    logic [DW-1:0] r_b5, r_t5;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b5 <= w_b6 + (r_ap5[1] << 17) + (w_p4 << 35);
            r_t5 <= psc_pkg::DIV_BIAS + DW'($signed(w_a3) >>> 8) + (r_ap2[1] << 12);
        end
    end

    // ---------------- stages 6-7: times p1 ----------------
    logic [DW-1:0] w_tp;
    logic [DW-1:0] r_b [0:1];
    psc_mul u_mul_tp (.i_clk, .i_en(w_en), .i_a(r_t5), .i_b(w_p1), .o_p(w_tp));
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b[0] <= r_b5;
            r_b[1] <= r_b[0];
        end
    end

    // ---------------- stage 8: divisor, fault, numerator base ----------------
    logic [DW-1:0] w_den8;
    logic [DW-1:0] r_den8, r_n8;
    logic          r_flt [psc_pkg::S_DEN:LAT-2];
    assign w_den8 = DW'($signed(w_tp) >>> 33);
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_den8             <= w_den8;
            r_flt[psc_pkg::S_DEN] <= (w_den8 == '0);
            r_n8               <= (r_praw[7] << 31) - r_b[1];
            for (int k = psc_pkg::S_DEN + 1; k < LAT - 1; k++) begin
                r_flt[k] <= r_flt[k-1];
            end
        end
    end

    // ---------------- stages 9-10: numerator times 3125 ----------------
    logic [DW-1:0] w_num;
    logic [DW-1:0] r_den [0:1];
    psc_mul u_mul_num (.i_clk, .i_en(w_en), .i_a(r_n8), .i_b(psc_pkg::NUM_SCALE),
                       .o_p(w_num));
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_den[0] <= r_den8;
            r_den[1] <= r_den[0];
        end
    end

    // ---------------- stage 11: magnitudes and quotient sign ----------------
    logic [DW-1:0] r_ua, r_ub;
    logic          r_sgn [psc_pkg::S_DIV_IN:psc_pkg::S_DIV_OUT];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ua <= w_num[DW-1] ? -w_num : w_num;
            // substitute a divisor of one on fault; the quotient is dropped anyway
            if (r_den[1] == '0) begin
                r_ub <= DW'(1);
            end else begin
                r_ub <= r_den[1][DW-1] ? -r_den[1] : r_den[1];
            end
            r_sgn[psc_pkg::S_DIV_IN] <= w_num[DW-1] ^ r_den[1][DW-1];
            for (int k = psc_pkg::S_DIV_IN + 1; k <= psc_pkg::S_DIV_OUT; k++) begin
                r_sgn[k] <= r_sgn[k-1];
            end
        end
    end

    // ---------------- divider ----------------
    logic [DW-1:0] w_quo;
    psc_div u_div (.i_clk, .i_en(w_en), .i_num(r_ua), .i_den(r_ub), .o_quo(w_quo));

    // ---------------- signed quotient ----------------
    logic [DW-1:0] r_p;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p <= r_sgn[psc_pkg::S_DIV_OUT] ? -w_quo : w_quo;
        end
    end

    // ---------------- q*q and p8*p ----------------
    logic [DW-1:0] w_q, w_qq, w_p8p;
    logic [DW-1:0] r_pd [0:3];
    assign w_q = DW'($signed(r_p) >>> 13);
    psc_mul u_mul_qq  (.i_clk, .i_en(w_en), .i_a(w_q), .i_b(w_q), .o_p(w_qq));
    psc_mul u_mul_p8p (.i_clk, .i_en(w_en), .i_a(r_p), .i_b(w_p8), .o_p(w_p8p));

    // ---------------- p9*q*q ----------------
    logic [DW-1:0] w_x;
    logic [DW-1:0] r_p8p [0:1];
    psc_mul u_mul_x (.i_clk, .i_en(w_en), .i_a(w_qq), .i_b(w_p9), .o_p(w_x));
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pd[0]  <= r_p;
            for (int k = 1; k < 4; k++) begin
                r_pd[k] <= r_pd[k-1];
            end
            r_p8p[0] <= w_p8p;
            r_p8p[1] <= r_p8p[0];
        end
    end

    // ---------------- final sum and output ----------------
    logic [DW-1:0] r_s;
    logic [DW-1:0] w_fin;
    assign w_fin = DW'($signed(r_s) >>> 8) + (w_p7 << 4);
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s <= r_pd[3] + DW'($signed(w_x) >>> 25) + DW'($signed(r_p8p[1]) >>> 19);
            o_result.divisor_fault  <= r_flt[LAT-2];
            o_result.pressure_q24_8 <= r_flt[LAT-2] ? psc_pkg::OUT_W'(r_raw[LAT-2])
                                                    : w_fin[psc_pkg::OUT_W-1:0];
        end
    end
endmodule
`default_nettype wire

// File: tb/sv/psc_checker.sv
// Result checker for the pressure compensation block: mirrors the coefficient
// registers from the APB port, predicts each sample's result and compares.
// Depends on psc_pkg and psc_if.
`timescale 1ns / 100ps
`default_nettype none
module psc_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    psc_sample_if.sink                      smp,
    psc_result_if.sink                      res,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [psc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [psc_pkg::APB_W-1:0]  pwdata,
    input  wire logic                       pready,
    output int                              o_fail_count,
    output int                              o_pending
);
    typedef struct packed {
        logic [psc_pkg::OUT_W-1:0] pressure;
        logic                      fault;
    } t_result;

    logic [15:0] coef [8];
    // coef[REG_P8_P9] holds P8; P9 sits in the upper half of the same register
    logic [15:0] coef_p9;
    t_result     expected_q[$];

    function automatic t_result compensate(logic [psc_pkg::RAW_W-1:0] raw,
                                           logic signed [psc_pkg::TEMP_W-1:0] tfine);
        logic signed [63:0] x, off, den, num, prs, q, c9, c8;
        t_result r;
        x   = 64'(tfine) - 64'sd128000;
        off = x * x * $signed(coef[psc_pkg::REG_P6]);
        off = off + ((x * $signed(coef[psc_pkg::REG_P5])) <<< 17);
        off = off + (64'($signed(coef[psc_pkg::REG_P4])) <<< 35);
        den = ((x * x * $signed(coef[psc_pkg::REG_P3])) >>> 8)
            + ((x * $signed(coef[psc_pkg::REG_P2])) <<< 12);
        den = ((64'sh0000_8000_0000_0000 + den)
              * $signed({48'd0, coef[psc_pkg::REG_P1]})) >>> 33;
        if (den == 0) begin
            r.pressure = psc_pkg::OUT_W'(raw);
            r.fault    = 1'b1;
            return r;
        end
        prs = 64'sd1048576 - $signed({44'd0, raw});
        num = ((prs <<< 31) - off) * 64'sd3125;
        // the most negative value over -1 wraps to itself
        if (den == -64'sd1) prs = -num;
        else                prs = num / den;
        q   = prs >>> 13;
        c9  = 64'($signed(coef_p9));
        c8  = 64'($signed(coef[psc_pkg::REG_P8_P9]));
        c9  = (c9 * q * q) >>> 25;
        c8  = (c8 * prs) >>> 19;
        prs = ((prs + c9 + c8) >>> 8) + (64'($signed(coef[psc_pkg::REG_P7])) <<< 4);
        r.pressure = prs[psc_pkg::OUT_W-1:0];
        r.fault    = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t mismatch: %s", $realtime, what);
        o_fail_count++;
    endtask

    initial o_pending = 0;

    always @(posedge i_clk) begin
        t_result got, exp_r;
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) coef[i] <= '0;
            coef_p9      <= '0;
            o_fail_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[4:2] == psc_pkg::REG_P8_P9) begin
                    coef[psc_pkg::REG_P8_P9] <= pwdata[15:0];
                    coef_p9                  <= pwdata[31:16];
                end else begin
                    coef[paddr[4:2]] <= pwdata[15:0];
                end
            end
            if (smp.valid && smp.ready)
                expected_q.push_back(compensate(smp.raw_pressure, smp.fine_temperature));
            if (res.valid && res.ready) begin
                got = '{res.pressure_q24_8, res.divisor_fault};
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", got.pressure));
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got.pressure !== exp_r.pressure)
                        report_mismatch($sformatf("pressure got %h want %h",
                                                  got.pressure, exp_r.pressure));
                    if (got.fault !== exp_r.fault)
                        report_mismatch($sformatf("fault got %b want %b",
                                                  got.fault, exp_r.fault));
                end
            end
        end
        o_pending = expected_q.size();
    end
endmodule
`default_nettype wire

// File: tb/sv/tb_pressure_sensor_compensation.sv
// Testbench top for pressure_sensor_compensation: drives samples, result stalls and
// coefficient writes; psc_checker predicts and compares. Depends on psc_pkg, psc_if.
`timescale 1ns / 100ps
`default_nettype none
module tb_pressure_sensor_compensation;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_RANDOM       = 1080;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [psc_pkg::ADDR_W-1:0] paddr = '0;
    logic [psc_pkg::APB_W-1:0]  pwdata = '0;
    logic [psc_pkg::APB_W-1:0]  prdata;
    logic                       pready;
    int fail_count, pending, idle_cycles;

    psc_sample_if smp ();
    psc_result_if res ();

    initial begin
        smp.valid = 1'b0;
        smp.raw_pressure = '0;
        smp.fine_temperature = '0;
        res.ready = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    pressure_sensor_compensation u_top (
        .i_clk, .i_rst_n, .i_sample(smp.sink), .o_result(res.source),
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    psc_checker u_checker (
        .i_clk, .i_rst_n, .smp(smp.sink), .res(res.sink),
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Draw a gap length: mostly none or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Watchdog: count cycles without any transfer while the run is live.
    always @(posedge i_clk) begin
        if ((smp.valid && smp.ready) || (res.valid && res.ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: stall at random, with quiet stretches of full readiness.
    bit stall_on = 1'b1;
    initial begin
        int g;
        @(posedge i_clk);
        forever begin
            g = stall_on ? gap_len() : 0;
            if (g > 0) begin
                res.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            res.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Write one coefficient register: setup phase, then access phase.
    task automatic write_coef(psc_pkg::t_reg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= psc_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Send one sample, holding valid until the transfer; idle first if asked.
    // Ready is sampled in the middle of the cycle, where it holds until the edge.
    task automatic send_sample(logic [psc_pkg::RAW_W-1:0] raw, logic [31:0] tf, int g);
        bit taken;
        if (g > 0) begin
            smp.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        smp.valid            <= 1'b1;
        smp.raw_pressure     <= raw;
        smp.fine_temperature <= tf;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = smp.ready;
            @(posedge i_clk);
        end
    endtask

    // Drain every outstanding result, then let the pipeline settle.
    task automatic drain();
        smp.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (psc_pkg::PIPE_LAT + 10) @(posedge i_clk);
    endtask

    // Load a whole coefficient set.
    task automatic load_set(logic [15:0] c1, c2, c3, c4, c5, c6, c7, logic [31:0] c89);
        write_coef(psc_pkg::REG_P1, {16'hA5A5, c1});
        write_coef(psc_pkg::REG_P2, {16'h5A5A, c2});
        write_coef(psc_pkg::REG_P3, {16'hFFFF, c3});
        write_coef(psc_pkg::REG_P4, 32'(c4));
        write_coef(psc_pkg::REG_P5, 32'(c5));
        write_coef(psc_pkg::REG_P6, 32'(c6));
        write_coef(psc_pkg::REG_P7, 32'(c7));
        write_coef(psc_pkg::REG_P8_P9, c89);
    endtask

    // Random sample: mostly realistic temperatures, with full-range noise.
    task automatic random_sample();
        logic [31:0] tf;
        logic [psc_pkg::RAW_W-1:0] raw;
        raw = psc_pkg::RAW_W'($urandom);
        if ($urandom_range(3) != 0) tf = 32'($signed($urandom_range(200000)) - 40000);
        else                        tf = $urandom;
        send_sample(raw, tf, gap_len());
    endtask

    initial begin
        int k;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // All-zero coefficients: divisor is zero, raw passes through with fault.
        send_sample('0, 32'd0, 0);
        send_sample('1, 32'h7FFF_FFFF, 0);
        send_sample(20'h5_5555, 32'h8000_0000, 0);
        drain();

        // Typical datasheet calibration.
        load_set(16'd36477, -16'sd10685, 16'd3024, 16'd2855, 16'd140, -16'sd7,
                 16'd15500, {16'd6000, -16'sd14600});
        send_sample('0, 32'd128000, 0);          // zero temperature offset
        send_sample('1, 32'd128000, 0);
        send_sample(20'd415148, 32'd128422, 0);
        send_sample(20'd524288, 32'hFFFF_FFFF, 0);
        send_sample(20'd300000, 32'h7FFF_FFFF, 0);
        send_sample(20'd700000, 32'h8000_0000, 0);
        send_sample(20'hA_AAAA, 32'hAAAA_AAAA, 0);
        send_sample(20'h5_5555, 32'h5555_5555, 0);
        drain();

        // Extreme coefficients.
        load_set(16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                 16'h8000, 32'h8000_7FFF);
        send_sample('0, 32'd128000, 0);
        send_sample('1, 32'h8000_0000, 0);
        send_sample(20'd1, 32'h7FFF_FFFF, 0);
        send_sample(20'd1048575, 32'd0, 0);
        drain();
        load_set(16'd1, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                 16'h7FFF, 32'h7FFF_8000);
        send_sample('0, 32'd0, 0);
        send_sample('1, 32'h7FFF_FFFF, 0);
        send_sample(20'd12345, 32'd128000, 0);
        drain();

        // Random phases: random coefficients, the datasheet set every third phase; one phase with no idling or stalls.
        for (int ph = 0; ph < 9; ph++) begin
            if (ph % 3 == 2)
                load_set(16'd36477, -16'sd10685, 16'd3024, 16'd2855, 16'd140, -16'sd7,
                         16'd15500, {16'd6000, -16'sd14600});
            else
                load_set(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom), 16'($urandom), $urandom);
            stall_on = (ph != 4);
            for (k = 0; k < N_RANDOM / 9; k++) begin
                if (ph == 4) send_sample(psc_pkg::RAW_W'($urandom), $urandom, 0);
                else         random_sample();
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
